FILE: sv/thsm_pkg.sv
// ---------------------------------------------------------------------------
// Two-wire humidity sensor master: shared types and constants
// Payload structs, controller state record, sequence phase codes and the
// fixed bus command bytes.
// ---------------------------------------------------------------------------
package thsm_pkg;

    // Operation codes carried by an input transfer.
    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_MEASURE = 2'd1;
    localparam logic [1:0] OP_RESET   = 2'd2;

    // Command bytes sent on the bus.
    localparam logic [7:0] CMD_TEMP  = 8'h03;
    localparam logic [7:0] CMD_HUMI  = 8'h05;
    localparam logic [7:0] CMD_RESET = 8'h1e;

    localparam logic [3:0]  RESET_PULSES    = 4'd9;
    localparam logic [15:0] TIMEOUT_DEFAULT = 16'd2000;

    // Start waveform, one bit per tick, tick 0 in bit 0. Tick 8 is the last.
    localparam logic [15:0] START_SCK = 16'b0000_0000_1100_0110;
    localparam logic [15:0] START_DAT = 16'b0000_0001_1000_0011;

    // Sequence phases.
    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_CR_PRE   = 4'd1;
    localparam logic [3:0] PH_CR_PULSE = 4'd2;
    localparam logic [3:0] PH_CR_GAP   = 4'd3;
    localparam logic [3:0] PH_START    = 4'd4;
    localparam logic [3:0] PH_WRITE    = 4'd5;
    localparam logic [3:0] PH_WACK     = 4'd6;
    localparam logic [3:0] PH_WAIT     = 4'd7;
    localparam logic [3:0] PH_READ1    = 4'd8;
    localparam logic [3:0] PH_RACK1    = 4'd9;
    localparam logic [3:0] PH_READ2    = 4'd10;
    localparam logic [3:0] PH_RACK2    = 4'd11;

    typedef struct packed {
        logic [1:0] operation;
        logic       mode;
        logic       data_in;
    } in_t;

    typedef struct packed {
        logic        sck;
        logic        data_oe;
        logic        data_out;
        logic        busy_res;
        logic        done_res;
        logic [15:0] measurement;
        logic [1:0]  error_count;
        logic        rejected;
    } out_t;

    typedef struct packed {
        logic [3:0]  phase;
        logic [3:0]  bit_pos;
        logic [1:0]  hold;
        logic [15:0] wait_cnt;
        logic [7:0]  shift_byte;
        logic [15:0] result_word;
        logic [1:0]  err_tally;
    } state_t;

endpackage

FILE: sv/two_wire_humidity_sensor_master_core.sv
// ---------------------------------------------------------------------------
// Two-wire humidity sensor master core
// Tick-driven bit-level master for a two-wire humidity and temperature
// sensor bus, with a registered result stage.
// ---------------------------------------------------------------------------
// Each input transfer is one bus delay tick: it carries the sampled DATA
// level and optionally a command (measure or soft reset). Each accepted tick
// yields exactly one result transfer with the clock and DATA levels to drive
// for that tick and the sequence status; on the last tick of a sequence
// the 16-bit reading and the error count are shown. The core takes one tick
// per clock cycle, bounded by the single result register: a new tick is
// taken whenever that register is empty or being emptied in the same
// cycle, so a stalled consumer holds off the input side and nothing is
// lost. The result appears in the output register in the cycle after the
// input transfer. The wait timeout register resets to 2000 ticks and
// should only be written while no sequence is running.
module two_wire_humidity_sensor_master_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  thsm_pkg::in_t    in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output thsm_pkg::out_t   out_data,
    input  logic             cfg_we,
    input  logic [15:0]      cfg_wdata
);
    import thsm_pkg::*;

    state_t      state_reg;
    state_t      state_next;
    out_t        out_data_reg;
    out_t        out_data_next;
    logic        out_valid_reg;
    logic [15:0] timeout_reg;
    logic        in_xfer;

    // The result register can take a new tick when it is empty or when its
    // current content leaves in this same cycle.
    assign in_ready = !out_valid_reg || out_ready;
    assign in_xfer  = in_valid && in_ready;

    thsm_step u_step (
        .state_cur   (state_reg),
        .item        (in_data),
        .timeout     (timeout_reg),
        .state_next  (state_next),
        .result_next (out_data_next)
    );

    // Controller state moves forward only on an accepted tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (in_xfer)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_DEFAULT;
        end
        else if (cfg_we)
        begin
            timeout_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // The result payload needs no reset; it is only looked at with out_valid.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: sv/thsm_step.sv
// ---------------------------------------------------------------------------
// Two-wire humidity sensor master: tick logic
// Works out the bus levels and status of one tick and the controller state
// that follows it.
// ---------------------------------------------------------------------------
module thsm_step (
    input  thsm_pkg::state_t state_cur,
    input  thsm_pkg::in_t    item,
    input  logic [15:0]      timeout,
    output thsm_pkg::state_t state_next,
    output thsm_pkg::out_t   result_next
);
    import thsm_pkg::*;

    logic        dout;
    logic        cmd;
    logic [15:0] limit;

    function automatic logic [1:0] sat_inc(input logic [1:0] v);
        sat_inc = (v == 2'd3) ? v : v + 2'd1;
    endfunction

    assign cmd   = (item.operation == OP_MEASURE) || (item.operation == OP_RESET);
    // A zero timeout behaves as one tick.
    assign limit = (timeout == 16'd0) ? 16'd1 : timeout;

    always_comb
    begin
        state_next  = state_cur;
        result_next = '0;
        dout        = 1'b0;

        // A command taken while idle already drives the first tick of its waveform.
        if (state_cur.phase == PH_IDLE)
        begin
            if (cmd)
            begin
                state_next.bit_pos     = 4'd0;
                state_next.hold        = 2'd0;
                state_next.wait_cnt    = 16'd0;
                state_next.result_word = 16'd0;
                state_next.err_tally   = 2'd0;
                if (item.operation == OP_MEASURE)
                begin
                    state_next.shift_byte = item.mode ? CMD_HUMI : CMD_TEMP;
                    state_next.phase      = PH_START;
                end
                else
                begin
                    state_next.shift_byte = CMD_RESET;
                    state_next.phase      = PH_CR_PRE;
                end
            end
        end
        else if (cmd)
        begin
            result_next.rejected = 1'b1;
        end

        if (state_next.phase != PH_IDLE)
        begin
            result_next.busy_res = 1'b1;
            case (state_next.phase)
                PH_CR_PRE:
                begin
                    result_next.data_oe = 1'b1;
                    dout                = 1'b1;
                    state_next.phase    = PH_CR_PULSE;
                    state_next.bit_pos  = 4'd0;
                    state_next.hold     = 2'd0;
                end
                PH_CR_PULSE:
                begin
                    result_next.data_oe = 1'b1;
                    dout                = 1'b1;
                    result_next.sck     = (state_next.hold == 2'd0);
                    if (state_next.hold == 2'd0)
                    begin
                        state_next.hold = 2'd1;
                    end
                    else
                    begin
                        state_next.hold    = 2'd0;
                        state_next.bit_pos = state_next.bit_pos + 4'd1;
                        if (state_next.bit_pos >= RESET_PULSES)
                        begin
                            state_next.phase   = PH_CR_GAP;
                            state_next.bit_pos = 4'd0;
                        end
                    end
                end
                PH_CR_GAP:
                begin
                    result_next.data_oe = 1'b1;
                    dout                = 1'b1;
                    if (state_next.hold >= 2'd1)
                    begin
                        state_next.phase   = PH_START;
                        state_next.bit_pos = 4'd0;
                        state_next.hold    = 2'd0;
                    end
                    else
                    begin
                        state_next.hold = state_next.hold + 2'd1;
                    end
                end
                PH_START:
                begin
                    result_next.data_oe = 1'b1;
                    result_next.sck     = START_SCK[state_next.bit_pos];
                    dout                = START_DAT[state_next.bit_pos];
                    if (state_next.bit_pos >= 4'd8)
                    begin
                        state_next.phase   = PH_WRITE;
                        state_next.bit_pos = 4'd0;
                        state_next.hold    = 2'd0;
                    end
                    else
                    begin
                        state_next.bit_pos = state_next.bit_pos + 4'd1;
                    end
                end
                PH_WRITE:
                begin
                    result_next.data_oe = 1'b1;
                    // MSB first: bit 7 - n is the inverted low three bits of n.
                    dout            = state_next.shift_byte[~state_next.bit_pos[2:0]];
                    result_next.sck = (state_next.hold != 2'd0);
                    if (state_next.hold == 2'd0)
                    begin
                        state_next.hold = 2'd1;
                    end
                    else
                    begin
                        state_next.hold = 2'd0;
                        if (state_next.bit_pos >= 4'd7)
                        begin
                            state_next.phase   = PH_WACK;
                            state_next.bit_pos = 4'd0;
                        end
                        else
                        begin
                            state_next.bit_pos = state_next.bit_pos + 4'd1;
                        end
                    end
                end
                PH_WACK:
                begin
                    if (state_next.hold == 2'd0)
                    begin
                        state_next.hold = 2'd1;
                    end
                    else if (state_next.hold == 2'd1)
                    begin
                        result_next.sck = 1'b1;
                        if (item.data_in)
                        begin
                            state_next.err_tally = sat_inc(state_next.err_tally);
                        end
                        state_next.hold = 2'd2;
                    end
                    else
                    begin
                        state_next.hold = 2'd0;
                        if (state_next.shift_byte == CMD_RESET)
                        begin
                            result_next.done_res = 1'b1;
                            state_next.phase     = PH_IDLE;
                        end
                        else
                        begin
                            state_next.phase    = PH_WAIT;
                            state_next.wait_cnt = 16'd0;
                        end
                    end
                end
                PH_WAIT:
                begin
                    state_next.wait_cnt = state_next.wait_cnt + 16'd1;
                    if (!item.data_in)
                    begin
                        state_next.phase   = PH_READ1;
                        state_next.bit_pos = 4'd0;
                        state_next.hold    = 2'd0;
                    end
                    else if (state_next.wait_cnt >= limit)
                    begin
                        state_next.err_tally = sat_inc(state_next.err_tally);
                        state_next.phase     = PH_READ1;
                        state_next.bit_pos   = 4'd0;
                        state_next.hold      = 2'd0;
                    end
                end
                PH_READ1, PH_READ2:
                begin
                    if (state_next.hold == 2'd0)
                    begin
                        result_next.sck = 1'b1;
                        // First byte fills bits 15..8, second byte bits 7..0.
                        state_next.result_word[{state_next.phase == PH_READ1,
                                                ~state_next.bit_pos[2:0]}] =
                            state_next.result_word[{state_next.phase == PH_READ1,
                                                    ~state_next.bit_pos[2:0]}]
                            | item.data_in;
                        state_next.hold = 2'd1;
                    end
                    else
                    begin
                        state_next.hold = 2'd0;
                        if (state_next.bit_pos >= 4'd7)
                        begin
                            state_next.phase   = (state_next.phase == PH_READ1) ?
                                                 PH_RACK1 : PH_RACK2;
                            state_next.bit_pos = 4'd0;
                        end
                        else
                        begin
                            state_next.bit_pos = state_next.bit_pos + 4'd1;
                        end
                    end
                end
                PH_RACK1, PH_RACK2:
                begin
                    if (state_next.hold == 2'd0)
                    begin
                        result_next.sck     = 1'b1;
                        result_next.data_oe = 1'b1;
                        dout                = (state_next.phase != PH_RACK1);
                        state_next.hold     = 2'd1;
                    end
                    else
                    begin
                        state_next.hold = 2'd0;
                        if (state_next.phase == PH_RACK1)
                        begin
                            state_next.phase   = PH_READ2;
                            state_next.bit_pos = 4'd0;
                        end
                        else
                        begin
                            result_next.done_res = 1'b1;
                            state_next.phase     = PH_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_next.phase     = PH_IDLE;
                    result_next.busy_res = 1'b0;
                end
            endcase
        end

        result_next.data_out = result_next.data_oe & dout;
        if (result_next.done_res)
        begin
            result_next.measurement = state_next.result_word;
            result_next.error_count = state_next.err_tally;
        end
    end

endmodule

FILE: sv/thsm_checker.sv
// ---------------------------------------------------------------------------
// Two-wire humidity sensor master: port checker
// Concurrent assertions on the core's ports, attached by a bind.
// ---------------------------------------------------------------------------
module thsm_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_ready,
    input logic           out_valid,
    input logic           out_ready,
    input thsm_pkg::out_t out_data
);
    import thsm_pkg::*;

    // Every accepted tick shows its result in the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted tick produced no result");

    // A result held back by the consumer stays put.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // The finishing tick belongs to the running sequence.
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.done_res |-> out_data.busy_res)
        else $error("done shown without busy");

    // Reading and error count are only shown on the finishing tick.
    a_fields_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.done_res |->
            out_data.measurement == 16'd0 && out_data.error_count == 2'd0)
        else $error("result fields set outside the finishing tick");

    // DATA is only driven high while the master owns the line.
    a_drive_owned: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.data_out |-> out_data.data_oe)
        else $error("data_out high while DATA released");

endmodule

bind two_wire_humidity_sensor_master_core thsm_checker u_thsm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

FILE: dv/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Two-wire humidity sensor master: self-checking testbench
// Streams bus ticks into the core and compares every returned tick with an
// in-bench model of the bus master. It covers measure and soft reset
// sequences, acknowledge and timeout errors, commands while busy, and
// timeout settings from zero to full scale, under random handshake gaps.
// ---------------------------------------------------------------------------
module tb;

    import thsm_pkg::*;

    // The spare operation code is not named in the package and acts as a
    // plain tick.
    localparam logic [1:0] OP_SPARE = 2'd3;

    // How the simulated sensor fills the bits that the master reads.
    localparam int FILL_RANDOM = 0;
    localparam int FILL_ONES   = 1;
    localparam int FILL_ZEROS  = 2;

    localparam int MAX_GAP        = 17;
    localparam int HOLD_OFF_LEN   = 150;
    localparam int RANDOM_TICKS   = 30;
    localparam int MAX_REPORTS    = 40;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    in_t      in_data;
    logic     out_valid;
    logic     out_ready;
    out_t     out_data;
    logic     cfg_we;
    logic [15:0] cfg_wdata;

    // Model state of the bus master, updated once per accepted tick.
    logic [3:0]  bus_phase;
    logic [3:0]  bit_idx;
    logic [1:0]  hold_idx;
    logic [15:0] wait_ticks;
    logic [7:0]  cmd_byte;
    logic [15:0] read_word;
    logic [1:0]  err_tally;
    logic        meas_kind;
    logic [15:0] timeout_ticks;

    // Bus levels and status predicted for each accepted tick, oldest first.
    out_t tick_outcomes[$];
    out_t want;

    // Behavior of the simulated sensor during the current sequence.
    bit          sensor_acks;
    int unsigned sensor_delay;
    int          sensor_fill;

    // Handshake idling controls shared by the test tasks and the receiver.
    bit tx_jitter;
    bit rx_jitter;
    int hold_off_cycles;

    int unsigned ticks_sent;
    int unsigned results_seen;
    int unsigned sequences_done;
    int unsigned rejects_seen;
    int unsigned error_reports;
    int unsigned timeout_writes;
    int unsigned mismatches;

    two_wire_humidity_sensor_master_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Free-running 10 ns clock.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Model of one bus tick. It returns the levels and status that the core
    // must produce for this tick and advances the model state.
    function automatic out_t sensor_master_step(input in_t tick);
        out_t       res;
        logic [15:0] limit;
        logic [3:0]  pos;
        res = '0;
        if (bus_phase == PH_IDLE)
        begin
            // A command on an idle tick starts its sequence, and this very
            // tick is already the first tick of the waveform.
            if (tick.operation == OP_MEASURE || tick.operation == OP_RESET)
            begin
                bit_idx    = '0;
                hold_idx   = '0;
                wait_ticks = '0;
                read_word  = '0;
                err_tally  = '0;
                if (tick.operation == OP_MEASURE)
                begin
                    meas_kind = tick.mode;
                    cmd_byte  = tick.mode ? CMD_HUMI : CMD_TEMP;
                    bus_phase = PH_START;
                end
                else
                begin
                    cmd_byte  = CMD_RESET;
                    bus_phase = PH_CR_PRE;
                end
            end
        end
        else if (tick.operation == OP_MEASURE || tick.operation == OP_RESET)
        begin
            res.rejected = 1'b1;
        end

        if (bus_phase != PH_IDLE)
        begin
            res.busy_res = 1'b1;
            case (bus_phase)
                PH_CR_PRE:
                begin
                    res.data_oe  = 1'b1;
                    res.data_out = 1'b1;
                    bus_phase    = PH_CR_PULSE;
                    bit_idx      = '0;
                    hold_idx     = '0;
                end
                PH_CR_PULSE:
                begin
                    res.data_oe  = 1'b1;
                    res.data_out = 1'b1;
                    res.sck      = (hold_idx == 2'd0);
                    if (hold_idx == 2'd0)
                    begin
                        hold_idx = 2'd1;
                    end
                    else
                    begin
                        hold_idx = 2'd0;
                        bit_idx  = bit_idx + 4'd1;
                        if (bit_idx >= RESET_PULSES)
                        begin
                            bus_phase = PH_CR_GAP;
                            bit_idx   = '0;
                        end
                    end
                end
                PH_CR_GAP:
                begin
                    res.data_oe  = 1'b1;
                    res.data_out = 1'b1;
                    if (hold_idx >= 2'd1)
                    begin
                        bus_phase = PH_START;
                        bit_idx   = '0;
                        hold_idx  = '0;
                    end
                    else
                    begin
                        hold_idx = hold_idx + 2'd1;
                    end
                end
                PH_START:
                begin
                    res.data_oe  = 1'b1;
                    res.sck      = START_SCK[bit_idx];
                    res.data_out = START_DAT[bit_idx];
                    if (bit_idx >= 4'd8)
                    begin
                        bus_phase = PH_WRITE;
                        bit_idx   = '0;
                        hold_idx  = '0;
                    end
                    else
                    begin
                        bit_idx = bit_idx + 4'd1;
                    end
                end
                PH_WRITE:
                begin
                    res.data_oe  = 1'b1;
                    res.data_out = cmd_byte[3'd7 - bit_idx[2:0]];
                    res.sck      = (hold_idx != 2'd0);
                    if (hold_idx == 2'd0)
                    begin
                        hold_idx = 2'd1;
                    end
                    else
                    begin
                        hold_idx = 2'd0;
                        if (bit_idx >= 4'd7)
                        begin
                            bus_phase = PH_WACK;
                            bit_idx   = '0;
                        end
                        else
                        begin
                            bit_idx = bit_idx + 4'd1;
                        end
                    end
                end
                PH_WACK:
                begin
                    if (hold_idx == 2'd0)
                    begin
                        hold_idx = 2'd1;
                    end
                    else if (hold_idx == 2'd1)
                    begin
                        // The acknowledge is sampled on the clock-high tick.
                        res.sck = 1'b1;
                        if (tick.data_in && err_tally != 2'd3)
                            err_tally = err_tally + 2'd1;
                        hold_idx = 2'd2;
                    end
                    else
                    begin
                        hold_idx = 2'd0;
                        if (cmd_byte == CMD_RESET)
                        begin
                            res.done_res = 1'b1;
                            bus_phase    = PH_IDLE;
                        end
                        else
                        begin
                            bus_phase  = PH_WAIT;
                            wait_ticks = '0;
                        end
                    end
                end
                PH_WAIT:
                begin
                    // A zero timeout acts as a timeout of one tick.
                    limit      = (timeout_ticks == 16'd0) ? 16'd1 : timeout_ticks;
                    wait_ticks = wait_ticks + 16'd1;
                    if (!tick.data_in)
                    begin
                        bus_phase = PH_READ1;
                        bit_idx   = '0;
                        hold_idx  = '0;
                    end
                    else if (wait_ticks >= limit)
                    begin
                        if (err_tally != 2'd3)
                            err_tally = err_tally + 2'd1;
                        bus_phase = PH_READ1;
                        bit_idx   = '0;
                        hold_idx  = '0;
                    end
                end
                PH_READ1, PH_READ2:
                begin
                    if (hold_idx == 2'd0)
                    begin
                        res.sck = 1'b1;
                        pos = ((bus_phase == PH_READ1) ? 4'd15 : 4'd7)
                              - {1'b0, bit_idx[2:0]};
                        read_word[pos] = read_word[pos] | tick.data_in;
                        hold_idx = 2'd1;
                    end
                    else
                    begin
                        hold_idx = 2'd0;
                        if (bit_idx >= 4'd7)
                        begin
                            bus_phase = (bus_phase == PH_READ1) ? PH_RACK1 : PH_RACK2;
                            bit_idx   = '0;
                        end
                        else
                        begin
                            bit_idx = bit_idx + 4'd1;
                        end
                    end
                end
                PH_RACK1, PH_RACK2:
                begin
                    if (hold_idx == 2'd0)
                    begin
                        // ACK after the first byte, noACK after the second.
                        res.sck      = 1'b1;
                        res.data_oe  = 1'b1;
                        res.data_out = (bus_phase == PH_RACK2);
                        hold_idx     = 2'd1;
                    end
                    else
                    begin
                        hold_idx = 2'd0;
                        if (bus_phase == PH_RACK1)
                        begin
                            bus_phase = PH_READ2;
                            bit_idx   = '0;
                        end
                        else
                        begin
                            res.done_res = 1'b1;
                            bus_phase    = PH_IDLE;
                        end
                    end
                end
                default:
                begin
                    bus_phase    = PH_IDLE;
                    res.busy_res = 1'b0;
                end
            endcase
        end

        if (res.done_res)
        begin
            res.measurement = read_word;
            res.error_count = err_tally;
        end
        return res;
    endfunction

    // DATA level that the simulated sensor shows on the next tick, chosen
    // from the model state before that tick.
    function automatic logic sensor_level();
        if (bus_phase == PH_WACK && hold_idx == 2'd1)
            return !sensor_acks;
        if (bus_phase == PH_WAIT)
            return (wait_ticks < sensor_delay);
        if ((bus_phase == PH_READ1 || bus_phase == PH_READ2) && hold_idx == 2'd0)
        begin
            if (sensor_fill == FILL_ONES)
                return 1'b1;
            if (sensor_fill == FILL_ZEROS)
                return 1'b0;
        end
        return 1'($urandom_range(0, 1));
    endfunction

    task automatic report_mismatch(input string what, input int unsigned expd,
                                   input int unsigned got);
        if (mismatches < MAX_REPORTS)
            $display("mismatch on %s at result %0d: expected %0h, got %0h",
                     what, results_seen, expd, got);
        mismatches++;
    endtask

    // Offers one tick on the input channel and waits for its transfer. The
    // task is entered and left at a falling edge. The expectation is formed
    // at the accepting edge, so the model state is current on return.
    task automatic send_tick(input in_t item);
        int gap;
        gap = (tx_jitter && $urandom_range(0, 1)) ? $urandom_range(0, MAX_GAP) : 0;
        if (gap != 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data  = item;
        in_valid = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tick_outcomes.push_back(sensor_master_step(item));
        ticks_sent++;
        @(negedge clk);
    endtask

    // Runs one command and keeps ticking until the model is idle again.
    // noise_pct sets how often a command is offered while the sequence runs.
    task automatic run_sequence(input logic [1:0] op, input logic kind,
                                input bit acks, input int unsigned delay,
                                input int fill, input int unsigned noise_pct);
        in_t item;
        sensor_acks  = acks;
        sensor_delay = delay;
        sensor_fill  = fill;
        item.operation = op;
        item.mode      = kind;
        item.data_in   = 1'($urandom_range(0, 1));
        send_tick(item);
        while (bus_phase != PH_IDLE)
        begin
            item.operation = OP_TICK;
            if ($urandom_range(0, 99) < noise_pct)
                item.operation = 2'($urandom_range(OP_MEASURE, OP_SPARE));
            item.mode    = 1'($urandom_range(0, 1));
            item.data_in = sensor_level();
            send_tick(item);
        end
    endtask

    // Ticks with no command, with either the tick-only or the spare code.
    task automatic send_idle_ticks(input int count);
        in_t item;
        repeat (count)
        begin
            item.operation = $urandom_range(0, 1) ? OP_SPARE : OP_TICK;
            item.mode      = 1'($urandom_range(0, 1));
            item.data_in   = 1'($urandom_range(0, 1));
            send_tick(item);
        end
    endtask

    // The timeout register is written only while no sequence runs and every
    // result has come back.
    task automatic set_timeout(input logic [15:0] value);
        in_valid = 1'b0;
        while (tick_outcomes.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
        cfg_wdata = value;
        cfg_we    = 1'b1;
        @(negedge clk);
        cfg_we        = 1'b0;
        timeout_ticks = value;
        timeout_writes++;
    endtask

    // A humidity measurement at the timeout left by reset, with a missing
    // acknowledge and a sensor that answers well inside the wait; every bit
    // read is a one.
    task automatic test_measure_default_timeout();
        run_sequence(OP_MEASURE, 1'b1, 1'b0, 6, FILL_ONES, 0);
    endtask

    // Soft reset with a missing acknowledge; the reading stays zero.
    task automatic test_soft_reset();
        run_sequence(OP_RESET, 1'b0, 1'b0, 0, FILL_RANDOM, 0);
    endtask

    // Commands offered mid-sequence must be ignored and flagged, while the
    // spare code and plain ticks in idle do nothing.
    task automatic test_commands_while_busy();
        send_idle_ticks(2);
        run_sequence(OP_MEASURE, 1'b0, 1'b1, 3, FILL_RANDOM, 35);
        send_idle_ticks(2);
    endtask

    // Timeout register at both ends and at the boundary. A zero setting
    // expires after one tick, and a sensor that answers on the last allowed
    // tick must not count as a timeout.
    task automatic test_timeout_settings();
        set_timeout(16'd0);
        run_sequence(OP_MEASURE, 1'b0, 1'b1, 5, FILL_RANDOM, 0);
        set_timeout(16'd3);
        run_sequence(OP_MEASURE, 1'b1, 1'b1, 2, FILL_RANDOM, 0);
        set_timeout(16'hffff);
        run_sequence(OP_MEASURE, 1'b1, 1'b1, 4, FILL_ZEROS, 0);
    endtask

    // The receiver holds off for a long stretch while ticks keep coming with
    // no gaps, so the result register fills and the input side stalls.
    task automatic test_output_stall();
        set_timeout(16'd10);
        tx_jitter       = 1'b0;
        hold_off_cycles = HOLD_OFF_LEN;
        run_sequence(OP_MEASURE, 1'b0, 1'b1, 4, FILL_RANDOM, 5);
        tx_jitter = 1'b1;
    endtask

    // Mostly well-formed sequences with random content and short timeouts,
    // mixed with idle ticks, stray commands and failing sensors.
    task automatic test_random_traffic();
        int unsigned first;
        int unsigned pick;
        int unsigned eff;
        set_timeout(16'd12);
        first = ticks_sent;
        while (ticks_sent - first < RANDOM_TICKS)
        begin
            tx_jitter = ($urandom_range(0, 3) != 0);
            rx_jitter = ($urandom_range(0, 3) != 0);
            pick      = $urandom_range(0, 99);
            eff       = (timeout_ticks == 16'd0) ? 1 : timeout_ticks;
            if (pick < 10)
                send_idle_ticks($urandom_range(1, 4));
            else if (pick < 20)
                set_timeout(16'($urandom_range(0, 40)));
            else
                run_sequence(($urandom_range(0, 2) == 0) ? OP_RESET : OP_MEASURE,
                             1'($urandom_range(0, 1)), ($urandom_range(0, 9) != 0),
                             $urandom_range(0, eff + 2), FILL_RANDOM,
                             ($urandom_range(0, 5) == 0) ? 15 : 0);
        end
        tx_jitter = 1'b1;
        rx_jitter = 1'b1;
    endtask

    // Result side: a random stall before each transfer, plus one long
    // hold-off when a test asks for it.
    initial
    begin
        int gap;
        out_ready = 1'b0;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_off_cycles != 0)
            begin
                out_ready = 1'b0;
                repeat (hold_off_cycles) @(negedge clk);
                hold_off_cycles = 0;
            end
            gap = (rx_jitter && $urandom_range(0, 1)) ? $urandom_range(0, MAX_GAP) : 0;
            if (gap != 0)
            begin
                out_ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready = 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    // Each result transfer is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (tick_outcomes.size() == 0)
            begin
                report_mismatch("result with nothing expected", 0, out_data);
            end
            else
            begin
                want = tick_outcomes.pop_front();
                if (out_data.sck !== want.sck)
                    report_mismatch("sck", want.sck, out_data.sck);
                if (out_data.data_oe !== want.data_oe)
                    report_mismatch("data_oe", want.data_oe, out_data.data_oe);
                if (out_data.data_out !== want.data_out)
                    report_mismatch("data_out", want.data_out, out_data.data_out);
                if (out_data.busy_res !== want.busy_res)
                    report_mismatch("busy_res", want.busy_res, out_data.busy_res);
                if (out_data.done_res !== want.done_res)
                    report_mismatch("done_res", want.done_res, out_data.done_res);
                if (out_data.measurement !== want.measurement)
                    report_mismatch("measurement", want.measurement, out_data.measurement);
                if (out_data.error_count !== want.error_count)
                    report_mismatch("error_count", want.error_count, out_data.error_count);
                if (out_data.rejected !== want.rejected)
                    report_mismatch("rejected", want.rejected, out_data.rejected);
                if (want.done_res)
                    sequences_done++;
                if (want.rejected)
                    rejects_seen++;
                if (want.done_res && want.error_count != 2'd0)
                    error_reports++;
            end
            results_seen++;
        end
    end

    // Watchdog: far beyond the slowest legal run, with every tick taking the
    // longest gap on both sides.
    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        tx_jitter = 1'b1;
        rx_jitter = 1'b1;
        hold_off_cycles = 0;
        ticks_sent      = 0;
        results_seen    = 0;
        sequences_done  = 0;
        rejects_seen    = 0;
        error_reports   = 0;
        timeout_writes  = 0;
        mismatches      = 0;
        sensor_acks     = 1'b1;
        sensor_delay    = 0;
        sensor_fill     = FILL_RANDOM;

        // Model state after reset.
        bus_phase     = PH_IDLE;
        bit_idx       = '0;
        hold_idx      = '0;
        wait_ticks    = '0;
        cmd_byte      = '0;
        read_word     = '0;
        err_tally     = '0;
        meas_kind     = 1'b0;
        timeout_ticks = TIMEOUT_DEFAULT;

        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_measure_default_timeout();
        test_soft_reset();
        test_commands_while_busy();
        test_timeout_settings();
        test_output_stall();
        test_random_traffic();

        // Drain: every prediction must be matched by a result transfer.
        in_valid = 1'b0;
        while (tick_outcomes.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        $display("Run covered %0d ticks and %0d finished sequences, %0d with errors.",
                 ticks_sent, sequences_done, error_reports);
        $display("It saw %0d ignored commands and %0d timeout register writes.",
                 rejects_seen, timeout_writes);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
sv/thsm_pkg.sv
sv/thsm_step.sv
sv/two_wire_humidity_sensor_master_core.sv
sv/thsm_checker.sv
dv/tb.sv
